// ===== hw/rtl/aust_pkg.sv =====
package aust_pkg;

  localparam int unsigned AngleW   = 12;
  localparam int unsigned ElapsedW = 24;
  localparam int unsigned SpeedW   = 26;
  localparam int unsigned DegW     = 32;
  localparam int unsigned CountW   = 40;
  // unwrapped difference never leaves -2048..2048
  localparam int unsigned DiffW    = AngleW + 1;
  localparam int unsigned UsecW    = 26;
  localparam int unsigned SpdNumW  = AngleW + UsecW;
  localparam int unsigned DegMulW  = 10;
  localparam int unsigned DegProdW = CountW + DegMulW - 1;
  localparam int unsigned DegNumW  = DegProdW - 1;

  // one revolution of the sensor; a power of two, so degree scaling is a shift
  localparam int unsigned LsbPerRev     = 4096;
  localparam int unsigned LsbPerRevLog2 = $clog2(LsbPerRev);

  localparam logic [UsecW-1:0]          UsecPerMin = 26'd60000000;
  localparam logic signed [DegMulW-1:0] DegPerRev  = 10'sd360;

  localparam logic OpSample = 1'b0;
  localparam logic OpZero   = 1'b1;

  typedef struct packed {
    logic                op;
    logic [AngleW-1:0]   angle_raw;
    logic [ElapsedW-1:0] elapsed_us;
  } in_t;

  typedef struct packed {
    logic signed [SpeedW-1:0] speed_rpm;
    logic signed [DegW-1:0]   cum_degrees;
  } out_t;

  typedef enum logic [2:0] {
    StIdle,
    StUnwrap,
    StScale,
    StDegMul,
    StStart,
    StDivide,
    StWrite
  } state_e;

  typedef struct packed {
    logic load;
    logic unwrap;
    logic scale;
    logic deg_mul;
    logic start;
    logic write;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } status_t;

endpackage

// ===== hw/rtl/aust_div.sv =====
module aust_div #(
  parameter int unsigned NumW = 48,
  parameter int unsigned DenW = 17
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic [NumW-1:0] quot_o,
  output logic            done_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0] num_q, num_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;

  logic [DenW:0]   trial;
  logic [DenW:0]   trial_sub;
  logic            qbit;

  // restoring division, one quotient bit per cycle; quotient shifts in at the lsb
  assign trial     = {rem_q, num_q[NumW-1]};
  assign trial_sub = trial - {1'b0, den_q};
  assign qbit      = (trial >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = CntW'(NumW);
      num_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      num_d = {num_q[NumW-2:0], qbit};
      rem_d = qbit ? trial_sub[DenW-1:0] : trial[DenW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign quot_o = num_q;
  assign done_o = done_q;

endmodule

// ===== hw/rtl/aust_ctrl.sv =====
module aust_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  aust_pkg::status_t status_i,
  output aust_pkg::cmd_t    cmd_o
);

  aust_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      aust_pkg::StIdle:   if (in_valid_i) state_d = aust_pkg::StUnwrap;
      aust_pkg::StUnwrap: state_d = aust_pkg::StScale;
      aust_pkg::StScale:  state_d = aust_pkg::StDegMul;
      aust_pkg::StDegMul: state_d = aust_pkg::StStart;
      aust_pkg::StStart:  state_d = aust_pkg::StDivide;
      aust_pkg::StDivide: if (status_i.div_done) state_d = aust_pkg::StWrite;
      aust_pkg::StWrite:  if (status_i.out_free) state_d = aust_pkg::StIdle;
      default:            state_d = aust_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      aust_pkg::StIdle: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      aust_pkg::StUnwrap: cmd_o.unwrap  = 1'b1;
      aust_pkg::StScale:  cmd_o.scale   = 1'b1;
      aust_pkg::StDegMul: cmd_o.deg_mul = 1'b1;
      aust_pkg::StStart:  cmd_o.start   = 1'b1;
      aust_pkg::StDivide: cmd_o         = '0;
      aust_pkg::StWrite:  cmd_o.write   = status_i.out_free;
      default:            cmd_o         = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aust_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/aust_datapath.sv =====
module aust_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  aust_pkg::in_t     in_item_i,
  input  aust_pkg::cmd_t    cmd_i,
  output aust_pkg::status_t status_o,
  input  logic              cfg_we_i,
  input  logic              cfg_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output aust_pkg::out_t    out_item_o
);

  localparam int unsigned CprW    = $clog2(aust_pkg::LsbPerRev + 1);
  localparam int unsigned WideW   = ((CprW > aust_pkg::AngleW) ? CprW : aust_pkg::AngleW) + 2;
  localparam int unsigned SpdDenW = CprW + aust_pkg::ElapsedW;
  localparam int unsigned SumW    = aust_pkg::CountW + 2;

  localparam logic signed [WideW-1:0] CprS  = WideW'(aust_pkg::LsbPerRev);
  localparam logic signed [WideW-1:0] HalfS = WideW'(aust_pkg::LsbPerRev / 2);
  localparam logic [CprW-1:0]         CprU  = CprW'(aust_pkg::LsbPerRev);

  localparam logic signed [aust_pkg::CountW-1:0] CntMax =
    {1'b0, {(aust_pkg::CountW-1){1'b1}}};
  localparam logic signed [aust_pkg::CountW-1:0] CntMin =
    {1'b1, {(aust_pkg::CountW-1){1'b0}}};
  localparam logic signed [SumW-1:0] CntMaxExt = {2'b00, CntMax};
  localparam logic signed [SumW-1:0] CntMinExt = {2'b11, CntMin};

  localparam logic [aust_pkg::DegNumW-1:0] DegPosLim = aust_pkg::DegNumW'(32'h7FFF_FFFF);
  localparam logic [aust_pkg::DegNumW-1:0] DegNegLim = aust_pkg::DegNumW'(33'h0_8000_0000);

  // architectural state
  logic                                  rev_q;
  logic [aust_pkg::AngleW-1:0]           prev_angle_q;
  logic signed [aust_pkg::CountW-1:0]    cum_q;
  logic signed [aust_pkg::SpeedW-1:0]    last_speed_q;

  // per-item working registers
  aust_pkg::in_t                         in_q;
  logic signed [aust_pkg::DiffW-1:0]     diff_q;
  logic [aust_pkg::SpdNumW-1:0]          spd_num_q;
  logic [SpdDenW-1:0]                    spd_den_q;
  logic                                  spd_neg_q;
  logic                                  spd_zero_q;
  logic signed [aust_pkg::DegProdW-1:0]  deg_prod_q;
  logic [aust_pkg::DegNumW-1:0]          deg_quot_q;

  logic                                  out_valid_q;
  aust_pkg::out_t                        out_q;

  // unwrap
  logic signed [WideW-1:0]               raw_diff;
  logic signed [WideW-1:0]               wrap_diff;

  always_comb begin
    raw_diff = $signed(WideW'(in_q.angle_raw)) - $signed(WideW'(prev_angle_q));
    if (raw_diff > HalfS) begin
      wrap_diff = raw_diff - CprS;
    end else if (raw_diff < -HalfS) begin
      wrap_diff = raw_diff + CprS;
    end else begin
      wrap_diff = raw_diff;
    end
  end

  // count update and speed operands
  logic [aust_pkg::DiffW-1:0]            diff_neg;
  logic [aust_pkg::AngleW-1:0]           diff_mag;
  logic signed [SumW-1:0]                cum_ext;
  logic signed [SumW-1:0]                diff_ext;
  logic signed [SumW-1:0]                cum_sum;
  logic signed [aust_pkg::CountW-1:0]    cum_sat;

  always_comb begin
    diff_neg = -diff_q;
    diff_mag = diff_q[aust_pkg::DiffW-1] ? diff_neg[aust_pkg::AngleW-1:0]
                                          : diff_q[aust_pkg::AngleW-1:0];
    cum_ext  = {{2{cum_q[aust_pkg::CountW-1]}}, cum_q};
    diff_ext = {{(SumW-aust_pkg::DiffW){diff_q[aust_pkg::DiffW-1]}}, diff_q};
    cum_sum  = rev_q ? (cum_ext - diff_ext) : (cum_ext + diff_ext);
    if (cum_sum > CntMaxExt) begin
      cum_sat = CntMax;
    end else if (cum_sum < CntMinExt) begin
      cum_sat = CntMin;
    end else begin
      cum_sat = cum_sum[aust_pkg::CountW-1:0];
    end
  end

  // shift and divider operands, magnitudes only
  logic [aust_pkg::DegProdW-1:0]         deg_prod_neg;
  logic [aust_pkg::DegNumW-1:0]          deg_num;
  logic                                  deg_neg;
  logic [aust_pkg::SpdNumW-1:0]          spd_quot;
  logic                                  spd_done;

  assign deg_neg      = deg_prod_q[aust_pkg::DegProdW-1];
  assign deg_prod_neg = -deg_prod_q;
  assign deg_num      = deg_neg ? deg_prod_neg[aust_pkg::DegNumW-1:0]
                                : deg_prod_q[aust_pkg::DegNumW-1:0];

  aust_div #(
    .NumW (aust_pkg::SpdNumW),
    .DenW (SpdDenW)
  ) u_spd_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start),
    .num_i   (spd_num_q),
    .den_i   (spd_den_q),
    .quot_o  (spd_quot),
    .done_o  (spd_done)
  );

  // result formatting
  logic [aust_pkg::SpeedW-1:0]           spd_trunc;
  logic signed [aust_pkg::SpeedW-1:0]    spd_val;
  logic signed [aust_pkg::SpeedW-1:0]    speed_res;
  logic [aust_pkg::DegW-1:0]             deg_low_neg;
  logic signed [aust_pkg::DegW-1:0]      deg_res;
  logic                                  is_sample;

  always_comb begin
    is_sample = (in_q.op == aust_pkg::OpSample);
    spd_trunc = spd_quot[aust_pkg::SpeedW-1:0];
    if (spd_zero_q) begin
      spd_val = '0;
    end else if (spd_neg_q) begin
      spd_val = -$signed(spd_trunc);
    end else begin
      spd_val = $signed(spd_trunc);
    end
    speed_res = is_sample ? spd_val : last_speed_q;

    deg_low_neg = -deg_quot_q[aust_pkg::DegW-1:0];
    if (deg_neg) begin
      deg_res = (deg_quot_q > DegNegLim) ? $signed({1'b1, {(aust_pkg::DegW-1){1'b0}}})
                                         : $signed(deg_low_neg);
    end else begin
      deg_res = (deg_quot_q > DegPosLim) ? $signed({1'b0, {(aust_pkg::DegW-1){1'b1}}})
                                         : $signed(deg_quot_q[aust_pkg::DegW-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rev_q        <= 1'b0;
      prev_angle_q <= '0;
      cum_q        <= '0;
      last_speed_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        rev_q <= cfg_data_i;
      end
      if (cmd_i.scale) begin
        if (is_sample) begin
          cum_q        <= cum_sat;
          prev_angle_q <= in_q.angle_raw;
        end else begin
          cum_q <= '0;
        end
      end
      if (cmd_i.write) begin
        out_valid_q <= 1'b1;
        if (is_sample) begin
          last_speed_q <= spd_val;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= in_item_i;
    end
    if (cmd_i.unwrap) begin
      diff_q <= wrap_diff[aust_pkg::DiffW-1:0];
    end
    if (cmd_i.scale) begin
      spd_num_q  <= diff_mag * aust_pkg::UsecPerMin;
      spd_den_q  <= CprU * in_q.elapsed_us;
      spd_neg_q  <= diff_q[aust_pkg::DiffW-1] ^ !rev_q;
      spd_zero_q <= (in_q.elapsed_us == '0);
    end
    if (cmd_i.deg_mul) begin
      deg_prod_q <= cum_q * aust_pkg::DegPerRev;
    end
    // truncation toward zero on the magnitude
    if (cmd_i.start) begin
      deg_quot_q <= deg_num >> aust_pkg::LsbPerRevLog2;
    end
    if (cmd_i.write) begin
      out_q.speed_rpm   <= speed_res;
      out_q.cum_degrees <= deg_res;
    end
  end

  assign status_o.div_done = spd_done;
  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign out_item_o        = out_q;

endmodule

// ===== hw/rtl/angle_unwrap_speed_tracker_unit.sv =====
// Angle unwrap and speed tracker for an absolute rotary encoder.
// Input channel (in_valid_i / in_stall_o, payload in_item_i): each item is
// either a new angle sample with the microseconds since the last one, or a
// request to zero the cumulative count. Every item gives exactly one result.
// Output channel (out_valid_o / out_stall_i, payload out_item_o): speed in
// rpm and cumulative degrees, both truncated toward zero.
// Config channel (cfg_valid_i / cfg_ready_o, cfg_data_i): the reverse
// direction bit; ready is always high, write it only while the block is idle.
// An accepted item passes through the unwrap, scale, degree-multiply and
// start states, waits in the divide state until the serial divider is
// done, and is then written to the output register in the write state.
// One item is worked on at a time, so a new item is taken only once the
// last one has been written; the 38-step serial divider for the speed
// sets the pace, while the degree scaling is a shift.
// A finished result sits in an output register; the next item may be taken
// while it waits. If the receiver keeps stalling, the block holds the second
// result until the register frees up, and in_stall_o stays high meanwhile.
// Reset clears the previous angle, the count, the last speed and the
// direction bit, and leaves the output empty.
module angle_unwrap_speed_tracker_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  aust_pkg::in_t  in_item_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output aust_pkg::out_t out_item_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic           cfg_data_i
);

  aust_pkg::cmd_t    cmd;
  aust_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  aust_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  aust_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== sim/angle_unwrap_speed_tracker_checker.sv =====
module angle_unwrap_speed_tracker_checker
  import aust_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  in_t  in_item_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  out_t out_item_i,
  input  logic cfg_valid_i,
  input  logic cfg_ready_i,
  input  logic cfg_data_i,
  output int   mismatches_o,
  output int   pending_o,
  output int   results_o
);

  localparam longint CountsPerRev  = 4096;
  localparam longint HalfRev       = CountsPerRev / 2;
  localparam longint CountMax      = (longint'(1) <<< (CountW - 1)) - 1;
  localparam longint CountMin      = -CountMax - 1;
  localparam longint UsecPerMinute = 60000000;
  localparam longint DegreesPerRev = 360;
  localparam longint DegMax        = 2147483647;
  localparam longint DegMin        = -DegMax - 1;

  logic                     reverse_dir;
  logic [AngleW-1:0]        prev_angle;
  longint                   lsb_count;
  logic signed [SpeedW-1:0] last_speed;
  out_t                     expected_q[$];
  out_t                     want;

  // Advances the tracked encoder state by one item and returns its result.
  function automatic out_t track_item(input in_t it);
    longint diff;
    longint spd;
    longint deg;
    out_t   res;
    if (it.op == OpZero) begin
      lsb_count = 0;
    end else begin
      diff = longint'(it.angle_raw) - longint'(prev_angle);
      if (diff > HalfRev) diff -= CountsPerRev;
      else if (diff < -HalfRev) diff += CountsPerRev;
      if (reverse_dir) lsb_count -= diff;
      else lsb_count += diff;
      if (lsb_count > CountMax) lsb_count = CountMax;
      if (lsb_count < CountMin) lsb_count = CountMin;
      spd = 0;
      if (it.elapsed_us != '0) begin
        spd = (diff * UsecPerMinute) / (CountsPerRev * longint'(it.elapsed_us));
      end
      if (!reverse_dir) spd = -spd;
      last_speed = spd[SpeedW-1:0];
      prev_angle = it.angle_raw;
    end
    deg = (lsb_count * DegreesPerRev) / CountsPerRev;
    if (deg > DegMax) deg = DegMax;
    if (deg < DegMin) deg = DegMin;
    res.speed_rpm   = last_speed;
    res.cum_degrees = deg[DegW-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reverse_dir  = 1'b0;
      prev_angle   = '0;
      lsb_count    = 0;
      last_speed   = '0;
      expected_q.delete();
      mismatches_o = 0;
      pending_o    = 0;
      results_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) reverse_dir = cfg_data_i;
      // retire the outgoing result before queueing a new one
      if (out_valid_i && !out_stall_i) begin
        results_o++;
        if (expected_q.size() == 0) begin
          $error("result with no item outstanding: speed_rpm %0d cum_degrees %0d",
                 out_item_i.speed_rpm, out_item_i.cum_degrees);
          mismatches_o++;
        end else begin
          want = expected_q.pop_front();
          if (out_item_i.speed_rpm !== want.speed_rpm) begin
            $error("speed_rpm: expected %0d, got %0d", want.speed_rpm, out_item_i.speed_rpm);
            mismatches_o++;
          end
          if (out_item_i.cum_degrees !== want.cum_degrees) begin
            $error("cum_degrees: expected %0d, got %0d",
                   want.cum_degrees, out_item_i.cum_degrees);
            mismatches_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(track_item(in_item_i));
      pending_o = expected_q.size();
    end
  end

endmodule

// ===== sim/tb_angle_unwrap_speed_tracker_unit.sv =====
module tb_angle_unwrap_speed_tracker_unit;
  import aust_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int LongHold      = 600;
  localparam int RandomPhases  = 5;
  localparam int ItemsPerPhase = 200;
  localparam int DrainCycles   = 60;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_item   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data  = 1'b0;

  int mismatches;
  int pending;
  int results;

  int sent_total     = 0;
  int samples_sent   = 0;
  int zeros_sent     = 0;
  int dir_writes     = 0;
  int idle_cycles    = 0;
  int burst_left     = 0;
  bit sender_idles   = 1'b1;
  bit long_hold_done = 1'b0;
  logic [AngleW-1:0] cur_angle = '0;

  angle_unwrap_speed_tracker_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  angle_unwrap_speed_tracker_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .results_o    (results)
  );

  always #1 clk = ~clk;

  task automatic push_item(input logic op, input logic [AngleW-1:0] angle,
                           input logic [ElapsedW-1:0] elapsed);
    in_t it;
    int  gap;
    it.op         = op;
    it.angle_raw  = angle;
    it.elapsed_us = elapsed;
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent_total++;
    if (op == OpZero) begin
      zeros_sent++;
    end else begin
      samples_sent++;
      cur_angle = angle;
    end
    if (sender_idles && burst_left == 0) begin
      // long gaps land on different points of the divide
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end else if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  task automatic push_random();
    int                  pick;
    logic                op;
    logic [AngleW-1:0]   angle;
    logic [ElapsedW-1:0] elapsed;
    pick = $urandom_range(0, 9);
    case (pick)
      5: angle = AngleW'(cur_angle + 2048);
      6: angle = AngleW'(cur_angle + 2049);
      7: angle = AngleW'(cur_angle + 2047);
      8, 9: angle = AngleW'($urandom_range(0, 4095));
      default: angle = AngleW'(cur_angle + $urandom_range(0, 200) - 100);
    endcase
    pick = $urandom_range(0, 9);
    case (pick)
      0: elapsed = '0;
      1: elapsed = 24'd1;
      2: elapsed = '1;
      3, 4, 5, 6: elapsed = ElapsedW'($urandom_range(1, 2000));
      default: elapsed = ElapsedW'($urandom_range(0, 24'hFFFFFF));
    endcase
    op = ($urandom_range(0, 19) == 0) ? OpZero : OpSample;
    push_item(op, angle, elapsed);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_direction(input logic dir);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= dir;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    dir_writes++;
  endtask

  // receiver: random stall patterns, plus one long hold-off to back up the block
  initial begin
    int mode;
    int span;
    forever begin
      if (!long_hold_done && sent_total >= 400) begin
        repeat (LongHold) begin
          @(posedge clk);
          out_stall <= 1'b1;
        end
        long_hold_done = 1'b1;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(50, 400);
        repeat (span) begin
          @(posedge clk);
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ~out_stall;
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // forward direction from reset; first sample is taken against angle 0
    push_item(OpSample, 12'd100, 24'd1000);
    push_item(OpSample, 12'd4095, 24'd1);
    push_item(OpSample, 12'd0, 24'hFFFFFF);
    push_item(OpSample, 12'd2048, 24'd0);
    push_item(OpSample, 12'd0, 24'd1);
    push_item(OpSample, 12'd2049, 24'd1);
    push_item(OpSample, 12'd0, 24'd5);
    push_item(OpZero, 12'd4095, 24'hFFFFFF);
    push_item(OpSample, 12'd1, 24'd1);
    push_item(OpZero, 12'd0, 24'd0);
    push_item(OpSample, 12'd2048, 24'd1);
    push_item(OpSample, 12'd2048, 24'd100);

    set_direction(1'b1);
    push_item(OpSample, 12'd0, 24'd1);
    push_item(OpSample, 12'd2048, 24'd1);
    push_item(OpSample, 12'd10, 24'd0);
    push_item(OpZero, 12'd2048, 24'd7);
    push_item(OpSample, 12'd4095, 24'hFFFFFF);
    push_item(OpSample, 12'd2046, 24'd3);

    for (int p = 0; p < RandomPhases; p++) begin
      set_direction(p[0]);
      sender_idles = (p != 2);
      repeat (ItemsPerPhase) push_random();
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk);

    $display("Covered %0d angle samples and %0d count clears over %0d direction writes.",
             samples_sent, zeros_sent, dir_writes);
    $display("%0d results compared, with one %0d-cycle output hold-off.", results, LongHold);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
